FILE: hdl/tacc_pkg.sv
// Shared types, constants and wrap helpers for the touch alarm clock controller.
// No dependencies; used by tacc_hit, tacc_core and the top level.
`default_nettype none

package tacc_pkg;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned X_W      = 10;
    localparam int unsigned Y_W      = 11;

    localparam logic [MINUTE_W-1:0] HOUR_MAX   = 6'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [MINUTE_W-1:0] SECOND_MAX = 6'd59;

    localparam logic [HOUR_W-1:0]   HOUR_RST       = 5'd12;
    localparam logic [HOUR_W-1:0]   ALARM_HOUR_RST = 5'd6;
    localparam logic [MINUTE_W-1:0] ALARM_MIN_RST  = 6'd30;

    // Button rectangles, all bounds inclusive
    localparam logic [X_W-1:0] HOUR_COL_LO = 10'd80;
    localparam logic [X_W-1:0] HOUR_COL_HI = 10'd140;
    localparam logic [X_W-1:0] MIN_COL_LO  = 10'd510;
    localparam logic [X_W-1:0] MIN_COL_HI  = 10'd570;
    localparam logic [X_W-1:0] TOG_COL_LO  = 10'd210;
    localparam logic [X_W-1:0] TOG_COL_HI  = 10'd510;
    localparam logic [Y_W-1:0] UP_ROW_LO   = 11'd700;
    localparam logic [Y_W-1:0] UP_ROW_HI   = 11'd760;
    localparam logic [Y_W-1:0] DOWN_ROW_LO = 11'd790;
    localparam logic [Y_W-1:0] DOWN_ROW_HI = 11'd850;
    localparam logic [Y_W-1:0] TOG_ROW_LO  = 11'd1030;
    localparam logic [Y_W-1:0] TOG_ROW_HI  = 11'd1130;

    typedef enum logic [2:0] {
        HIT_TICK      = 3'd0,
        HIT_HOUR_UP   = 3'd1,
        HIT_HOUR_DOWN = 3'd2,
        HIT_MIN_UP    = 3'd3,
        HIT_MIN_DOWN  = 3'd4,
        HIT_TOGGLE    = 3'd5,
        HIT_OUTSIDE   = 3'd6
    } t_hit;

    // One request handed to the state update
    typedef struct packed {
        logic go;
        t_hit hit;
    } t_step;

    // Clock and alarm state after one request
    typedef struct packed {
        logic [HOUR_W-1:0]   hours;
        logic [MINUTE_W-1:0] minutes;
        logic [MINUTE_W-1:0] seconds;
        logic [HOUR_W-1:0]   alarm_hours;
        logic [MINUTE_W-1:0] alarm_minutes;
        logic                alarm_enable;
        logic                fire;
    } t_clock;

    function automatic logic [MINUTE_W-1:0] inc_wrap(input logic [MINUTE_W-1:0] v,
                                                     input logic [MINUTE_W-1:0] max);
        return (v >= max) ? '0 : v + 6'd1;
    endfunction

    // Out-of-range values land on max-1, as the counters treat them as the last value
    function automatic logic [MINUTE_W-1:0] dec_wrap(input logic [MINUTE_W-1:0] v,
                                                     input logic [MINUTE_W-1:0] max);
        logic [MINUTE_W-1:0] res;
        if (v > max) begin
            res = max - 6'd1;
        end else if (v == '0) begin
            res = max;
        end else begin
            res = v - 6'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tacc_hit.sv
// Touch hit test against the five button rectangles.
// Depends on tacc_pkg for bounds and hit codes.
`default_nettype none

module tacc_hit (
    input  wire logic                      i_cmd,
    input  wire logic [tacc_pkg::X_W-1:0]  i_x,
    input  wire logic [tacc_pkg::Y_W-1:0]  i_y,
    output tacc_pkg::t_hit                 o_hit
);

    logic w_hour_col, w_min_col, w_tog_col;
    logic w_up_row, w_down_row, w_tog_row;

    assign w_hour_col = (i_x >= tacc_pkg::HOUR_COL_LO) && (i_x <= tacc_pkg::HOUR_COL_HI);
    assign w_min_col  = (i_x >= tacc_pkg::MIN_COL_LO)  && (i_x <= tacc_pkg::MIN_COL_HI);
    assign w_tog_col  = (i_x >= tacc_pkg::TOG_COL_LO)  && (i_x <= tacc_pkg::TOG_COL_HI);
    assign w_up_row   = (i_y >= tacc_pkg::UP_ROW_LO)   && (i_y <= tacc_pkg::UP_ROW_HI);
    assign w_down_row = (i_y >= tacc_pkg::DOWN_ROW_LO) && (i_y <= tacc_pkg::DOWN_ROW_HI);
    assign w_tog_row  = (i_y >= tacc_pkg::TOG_ROW_LO)  && (i_y <= tacc_pkg::TOG_ROW_HI);

    // First rectangle that contains the point wins
    always_comb begin
        priority if (!i_cmd) begin
            o_hit = tacc_pkg::HIT_TICK;
        end else if (w_hour_col && w_up_row) begin
            o_hit = tacc_pkg::HIT_HOUR_UP;
        end else if (w_hour_col && w_down_row) begin
            o_hit = tacc_pkg::HIT_HOUR_DOWN;
        end else if (w_min_col && w_up_row) begin
            o_hit = tacc_pkg::HIT_MIN_UP;
        end else if (w_min_col && w_down_row) begin
            o_hit = tacc_pkg::HIT_MIN_DOWN;
        end else if (w_tog_col && w_tog_row) begin
            o_hit = tacc_pkg::HIT_TOGGLE;
        end else begin
            o_hit = tacc_pkg::HIT_OUTSIDE;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tacc_core.sv
// Time-of-day and alarm state registers with their combinational next-state update.
// Depends on tacc_pkg for types, limits and wrap helpers.
`default_nettype none

module tacc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tacc_pkg::t_step  i_step,
    output tacc_pkg::t_clock      o_next
);

    tacc_pkg::t_clock r_st;
    tacc_pkg::t_clock n_st;
    logic [tacc_pkg::MINUTE_W-1:0] w_hour6;

    assign w_hour6 = {1'b0, r_st.hours};

    always_comb begin
        n_st      = r_st;
        n_st.fire = 1'b0;
        unique case (i_step.hit)
            tacc_pkg::HIT_TICK: begin
                if (r_st.seconds >= tacc_pkg::SECOND_MAX) begin
                    n_st.seconds = '0;
                    if (r_st.minutes >= tacc_pkg::MINUTE_MAX) begin
                        n_st.minutes = '0;
                        n_st.hours   = tacc_pkg::HOUR_W'(
                            tacc_pkg::inc_wrap(w_hour6, tacc_pkg::HOUR_MAX));
                    end else begin
                        n_st.minutes = r_st.minutes + 6'd1;
                    end
                    n_st.fire = r_st.alarm_enable && (n_st.hours == r_st.alarm_hours)
                                && (n_st.minutes == r_st.alarm_minutes);
                end else begin
                    n_st.seconds = r_st.seconds + 6'd1;
                end
            end
            tacc_pkg::HIT_HOUR_UP: begin
                n_st.alarm_hours = tacc_pkg::HOUR_W'(tacc_pkg::inc_wrap(
                    {1'b0, r_st.alarm_hours}, tacc_pkg::HOUR_MAX));
            end
            tacc_pkg::HIT_HOUR_DOWN: begin
                n_st.alarm_hours = tacc_pkg::HOUR_W'(tacc_pkg::dec_wrap(
                    {1'b0, r_st.alarm_hours}, tacc_pkg::HOUR_MAX));
            end
            tacc_pkg::HIT_MIN_UP: begin
                n_st.alarm_minutes = tacc_pkg::inc_wrap(r_st.alarm_minutes,
                                                        tacc_pkg::MINUTE_MAX);
            end
            tacc_pkg::HIT_MIN_DOWN: begin
                n_st.alarm_minutes = tacc_pkg::dec_wrap(r_st.alarm_minutes,
                                                        tacc_pkg::MINUTE_MAX);
            end
            tacc_pkg::HIT_TOGGLE: begin
                n_st.alarm_enable = ~r_st.alarm_enable;
            end
            default: begin
                // outside: state holds
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.hours         <= tacc_pkg::HOUR_RST;
            r_st.minutes       <= '0;
            r_st.seconds       <= '0;
            r_st.alarm_hours   <= tacc_pkg::ALARM_HOUR_RST;
            r_st.alarm_minutes <= tacc_pkg::ALARM_MIN_RST;
            r_st.alarm_enable  <= 1'b0;
            r_st.fire          <= 1'b0;
        end else if (i_step.go) begin
            r_st <= n_st;
        end
    end

    assign o_next = n_st;

endmodule

`default_nettype wire

FILE: hdl/touch_alarm_clock_controller_unit.sv
// Top level of the touch alarm clock controller: input register, hit test,
// state update and result register. Depends on tacc_pkg, tacc_hit, tacc_core.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+--------------------------------------------
//   in      | i_in_valid  | o_in_stall  | i_cmd, i_touch_x, i_touch_y
//   out     | o_out_valid | i_out_stall | o_hour_now .. o_alarm_fire, o_button_hit
//
// One request per cycle sustained while the output is not stalled; a request passes
// the input register, then the hit test and state update land in the result register together.
// The state registers advance on the same edge that loads the result, so the
// next request already sees the updated clock and alarm.
// Synchronous active-low reset: time 12:00:00, alarm 06:30 disabled, both stages empty.
// A stall on the output holds a valid result and the input register; the input
// stalls only when its register is full and cannot move on.
`default_nettype none

module touch_alarm_clock_controller_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic [tacc_pkg::X_W-1:0]      i_touch_x,
    input  wire logic [tacc_pkg::Y_W-1:0]      i_touch_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tacc_pkg::HOUR_W-1:0]        o_hour_now,
    output logic [tacc_pkg::MINUTE_W-1:0]      o_minute_now,
    output logic [tacc_pkg::MINUTE_W-1:0]      o_second_now,
    output logic [tacc_pkg::HOUR_W-1:0]        o_alarm_hour_out,
    output logic [tacc_pkg::MINUTE_W-1:0]      o_alarm_minute_out,
    output logic                               o_alarm_on,
    output logic                               o_alarm_fire,
    output logic [2:0]                         o_button_hit
);

    // Input register
    logic                     r_s1_valid;
    logic                     r_s1_cmd;
    logic [tacc_pkg::X_W-1:0] r_s1_x;
    logic [tacc_pkg::Y_W-1:0] r_s1_y;

    // Result register
    logic             r_out_valid;
    tacc_pkg::t_clock r_out;
    tacc_pkg::t_hit   r_out_hit;

    logic             w_out_ready;
    tacc_pkg::t_hit   w_hit;
    tacc_pkg::t_step  w_step;
    tacc_pkg::t_clock n_clock;

    // Result register can load when empty or being drained this cycle
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Capture the payload only when a request is taken
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_cmd <= i_cmd;
            r_s1_x   <= i_touch_x;
            r_s1_y   <= i_touch_y;
        end
    end

    tacc_hit u_hit (
        .i_cmd (r_s1_cmd),
        .i_x   (r_s1_x),
        .i_y   (r_s1_y),
        .o_hit (w_hit)
    );

    assign w_step.go  = r_s1_valid && w_out_ready;
    assign w_step.hit = w_hit;

    tacc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_next  (n_clock)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Load the result alongside the state update
    always_ff @(posedge i_clk) begin
        if (w_step.go) begin
            r_out     <= n_clock;
            r_out_hit <= w_hit;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hour_now         = r_out.hours;
    assign o_minute_now       = r_out.minutes;
    assign o_second_now       = r_out.seconds;
    assign o_alarm_hour_out   = r_out.alarm_hours;
    assign o_alarm_minute_out = r_out.alarm_minutes;
    assign o_alarm_on         = r_out.alarm_enable;
    assign o_alarm_fire       = r_out.fire;
    assign o_button_hit       = r_out_hit;

`ifndef SYNTHESIS
    // A fire comes only from a tick that wrapped the seconds
    a_fire_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_fire) |->
            (o_button_hit == tacc_pkg::HIT_TICK && o_second_now == '0))
        else $error("alarm fired outside a minute boundary");

    // A fire means the enabled alarm matches the reported time
    a_fire_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_fire) |->
            (o_alarm_on && o_hour_now == o_alarm_hour_out
             && o_minute_now == o_alarm_minute_out))
        else $error("alarm fired without a matching enabled alarm");

    // Reported values stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hour_now <= 5'd23 && o_minute_now <= 6'd59
                         && o_second_now <= 6'd59 && o_alarm_hour_out <= 5'd23
                         && o_alarm_minute_out <= 6'd59))
        else $error("clock or alarm value out of range");

    // The input stalls only while both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without backpressure");
`endif

endmodule

`default_nettype wire
